@@ sv/newton_square_root_assert.svh @@
// ----------------------------------------------------------------------------
// newton_square_root assertion macros
// Concurrent check helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_ASSERT_SVH

`ifndef SYNTHESIS
`define NSR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("nsr: implication check failed");
`define NSR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("nsr: next-cycle check failed");
`else
`define NSR_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define NSR_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ sv/nsr_pkg.sv @@
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, defaults and result type of the square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int IN_W               = 32;
	localparam int ROOT_W             = 25;
	localparam int TOL_W              = 8;
	localparam int MAX_ITERATIONS_DEF = 48;
	localparam int FRAC_BITS_DEF      = 16;
	localparam int ROOT_MAX           = 16777215;

	localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              neg;
		logic              conv;
	} nsr_result_t;

endpackage

@@ sv/nsr_div.sv @@
// ----------------------------------------------------------------------------
// nsr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_div #(
	parameter int WIDTH = 47
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDTH-2:0], fits};
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/nsr_iter.sv @@
// ----------------------------------------------------------------------------
// nsr_iter
// Newton step sequencer around the serial divider.
// ----------------------------------------------------------------------------
module nsr_iter #(
	parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
	parameter int FRAC_BITS      = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nsr_pkg::IN_W-1:0]  x_value,
	input  logic [nsr_pkg::TOL_W-1:0] tol,
	output logic                      ready,
	output logic                      res_valid,
	input  logic                      res_take,
	output nsr_pkg::nsr_result_t      result
);

	import nsr_pkg::*;

	localparam int DW = IN_W - 1 + FRAC_BITS;
	localparam int SW = $clog2(MAX_ITERATIONS + 1);
	localparam logic [ROOT_W-1:0] NegRoot = ROOT_W'(0) - (ROOT_W'(1) << FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_CHK,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [DW-1:0] scaled_q;
	logic [DW-1:0] e0_q;
	logic [DW-1:0] e1_q;
	logic [SW-1:0] steps_q;
	logic          div_start_q;
	nsr_result_t   res_q;

	logic          div_done;
	logic [DW-1:0] quo;
	logic [DW-1:0] divisor;
	logic [DW:0]   sum;
	logic [DW-1:0] delta;
	logic [DW-1:0] root_sat;

	assign divisor  = (e0_q == '0) ? DW'(1) : e0_q;
	assign sum      = {1'b0, e0_q} + {1'b0, quo};
	assign delta    = (e1_q > e0_q) ? (e1_q - e0_q) : (e0_q - e1_q);
	assign root_sat = (e1_q > DW'(ROOT_MAX)) ? DW'(ROOT_MAX) : e1_q;

	nsr_div #(
		.WIDTH(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(scaled_q),
		.divisor (divisor),
		.done    (div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			steps_q     <= '0;
			scaled_q    <= '0;
			e0_q        <= '0;
			e1_q        <= '0;
			res_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (x_value[IN_W-1]) begin
							res_q   <= '{root: NegRoot, neg: 1'b1, conv: 1'b1};
							state_q <= ST_DONE;
						end else if (x_value == '0) begin
							res_q   <= '{root: '0, neg: 1'b0, conv: 1'b1};
							state_q <= ST_DONE;
						end else begin
							scaled_q    <= DW'(x_value[IN_W-2:0]) << FRAC_BITS;
							e0_q        <= DW'(x_value[IN_W-2:0]);
							steps_q     <= SW'(1);
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					e1_q    <= sum[DW:1];
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (delta <= DW'(tol)) begin
						res_q   <= '{root: root_sat[ROOT_W-1:0], neg: 1'b0, conv: 1'b1};
						state_q <= ST_DONE;
					end else if (steps_q >= SW'(MAX_ITERATIONS)) begin
						res_q   <= '{root: root_sat[ROOT_W-1:0], neg: 1'b0, conv: 1'b0};
						state_q <= ST_DONE;
					end else begin
						e0_q        <= e1_q;
						steps_q     <= steps_q + SW'(1);
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign result    = res_q;

endmodule

@@ sv/newton_square_root.sv @@
// ----------------------------------------------------------------------------
// newton_square_root
// Fixed-point square root by Newton-Raphson with a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | x_value
//  out      | out_valid / out_stall| root_value, negative_input, converged
//  cfg      | cfg_valid / cfg_ready| stop_tolerance
//
//  Negative and zero operands go from idle straight to the done state and then
//  to the output register. Other operands run up to MAX_ITERATIONS Newton
//  steps, each through the one-bit-per-cycle divider. One item is in work at
//  a time; the next is taken while a finished word waits in the output
//  register. Reset sets tolerance to 1.
// ----------------------------------------------------------------------------
module newton_square_root #(
	parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
	parameter int FRAC_BITS      = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [nsr_pkg::IN_W-1:0]  x_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [nsr_pkg::ROOT_W-1:0] root_value,
	output logic                             negative_input,
	output logic                             converged,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nsr_pkg::TOL_W-1:0]        stop_tolerance
);

	import nsr_pkg::*;

	`include "newton_square_root_assert.svh"

	localparam logic [ROOT_W-1:0] NegRoot = ROOT_W'(0) - (ROOT_W'(1) << FRAC_BITS);

	logic [TOL_W-1:0] tol_q;
	logic             out_valid_q;
	nsr_result_t      out_q;

	logic             iter_ready;
	logic             res_valid;
	logic             res_take;
	nsr_result_t      result;

	assign cfg_ready = 1'b1;
	assign in_stall  = !iter_ready;
	assign res_take  = res_valid && (!out_valid_q || !out_stall);

	nsr_iter #(
		.MAX_ITERATIONS(MAX_ITERATIONS),
		.FRAC_BITS     (FRAC_BITS)
	) u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && iter_ready),
		.x_value  (x_value),
		.tol      (tol_q),
		.ready    (iter_ready),
		.res_valid(res_valid),
		.res_take (res_take),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tol_q <= stop_tolerance;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign root_value     = out_q.root;
	assign negative_input = out_q.neg;
	assign converged      = out_q.conv;

	`NSR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`NSR_ASSERT_IMPLY(a_neg_word, clk, arst_n, out_valid && negative_input, root_value == NegRoot && converged)
	`NSR_ASSERT_IMPLY(a_capped_not_neg, clk, arst_n, out_valid && !converged, !negative_input)
	`NSR_ASSERT_IMPLY(a_root_sign, clk, arst_n, out_valid && !negative_input, !root_value[ROOT_W-1])

endmodule

@@ tb/sv/tb_newton_square_root.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newton_square_root
// Self-checking bench for the Newton-Raphson square root. A directed table
// covers zero, negative operands, field extremes and the tolerance extremes;
// random operands then run across several tolerance settings. Every result
// word is checked against a typed want or an in-bench model of the integer
// iteration, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_newton_square_root;
	import nsr_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int MAX_STEPS   = MAX_ITERATIONS_DEF;
	localparam int LIMIT       = 8000000;
	localparam int TAIL        = 200;
	localparam int REPORT_MAX  = 100;
	localparam int ROW_COUNT   = 24;
	localparam int PHASE_COUNT = 6;

	localparam logic [ROOT_W-1:0] NEG_ROOT = -(ROOT_W'(1) << FRAC);
	localparam logic [ROOT_W-1:0] ONE_ROOT = ROOT_W'(1) << FRAC;

	localparam nsr_result_t NEG_RESULT  = '{root: NEG_ROOT, neg: 1'b1, conv: 1'b1};
	localparam nsr_result_t ZERO_RESULT = '{root: '0, neg: 1'b0, conv: 1'b1};
	localparam nsr_result_t ONE_RESULT  = '{root: ONE_ROOT, neg: 1'b0, conv: 1'b1};
	localparam nsr_result_t UNTYPED     = '0;

	typedef struct {
		logic [IN_W-1:0]  x;
		logic [TOL_W-1:0] tol;
		bit               typed;
		nsr_result_t      want;
	} row_t;

	typedef struct packed {
		logic [IN_W-1:0] x;
		nsr_result_t     want;
	} pending_root_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [IN_W-1:0] x_value;
	logic out_valid;
	logic out_stall;
	logic signed [ROOT_W-1:0] root_value;
	logic negative_input;
	logic converged;
	logic cfg_valid;
	logic cfg_ready;
	logic [TOL_W-1:0] stop_tolerance;

	pending_root_t    pending_roots[$];
	logic [TOL_W-1:0] active_tol;
	bit               no_idle;
	int               fail_count  = 0;
	int               cycle_count = 0;
	row_t             directed_rows [ROW_COUNT];
	int               phase_items [PHASE_COUNT] = '{200, 60, 150, 150, 100, 70};
	logic [TOL_W-1:0] phase_tol [PHASE_COUNT];

	newton_square_root #(
		.MAX_ITERATIONS(MAX_STEPS),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_value(x_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.root_value(root_value),
		.negative_input(negative_input),
		.converged(converged),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.stop_tolerance(stop_tolerance)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic nsr_result_t predict_root(input logic [IN_W-1:0] x,
			input logic [TOL_W-1:0] tol);
		longint unsigned scaled;
		longint unsigned prev;
		longint unsigned est;
		longint unsigned diff;
		int steps;
		nsr_result_t r;
		r = ZERO_RESULT;
		if (x[IN_W-1]) begin
			r = NEG_RESULT;
		end else if (x != '0) begin
			scaled = 64'(x) << FRAC;
			prev = 64'(x);
			est = (prev + scaled / prev) >> 1;
			steps = 1;
			while (1) begin
				diff = (est > prev) ? est - prev : prev - est;
				if (diff <= 64'(tol))
					break;
				if (steps >= MAX_STEPS) begin
					r.conv = 1'b0;
					break;
				end
				prev = est;
				est = (prev + scaled / ((prev == 0) ? 64'd1 : prev)) >> 1;
				steps++;
			end
			r.root = (est > 64'(ROOT_MAX)) ? ROOT_W'(ROOT_MAX) : est[ROOT_W-1:0];
		end
		return r;
	endfunction

	// mostly none, some short, a few long
	function automatic int idle_len(input bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic send_word(input logic [IN_W-1:0] x, input bit typed,
			input nsr_result_t want);
		pending_root_t p;
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (in_stall);
		p.x = x;
		p.want = typed ? want : predict_root(x, active_tol);
		pending_roots.push_back(p);
		gap = idle_len(no_idle);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] tol);
		drain_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		stop_tolerance <= tol;
		do @(posedge clk); while (!cfg_ready);
		active_tol = tol;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : out_side
		int hold;
		bit stalled;
		out_stall = 1'b0;
		hold = 0;
		stalled = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				hold = idle_len(no_idle);
				stalled = (hold != 0);
				if (!stalled)
					hold = $urandom_range(1, 6);
			end
			out_stall <= stalled;
			hold--;
		end
	end

	always @(posedge clk) begin : check_word
		pending_root_t p;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_roots.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: unexpected word root=%h neg=%b conv=%b", $time,
						root_value, negative_input, converged);
			end else begin
				p = pending_roots.pop_front();
				if (p.want.root !== root_value || p.want.neg !== negative_input ||
						p.want.conv !== converged) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: x=%h root exp %h got %h, neg exp %b got %b, conv exp %b got %b",
							$time, p.x, p.want.root, root_value, p.want.neg,
							negative_input, p.want.conv, converged);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [IN_W-1:0] x;
		int unsigned r;
		in_valid = 1'b0;
		x_value = '0;
		cfg_valid = 1'b0;
		stop_tolerance = '0;
		no_idle = 1'b0;
		active_tol = TOL_RESET;
		arst_n = 1'b0;

		directed_rows = '{
			'{32'h0000_0000, 8'd1,   1'b1, ZERO_RESULT},
			'{32'hFFFF_FFFF, 8'd1,   1'b1, NEG_RESULT},
			'{32'h8000_0000, 8'd1,   1'b1, NEG_RESULT},
			'{32'hFFFF_0000, 8'd1,   1'b1, NEG_RESULT},
			'{32'h0001_0000, 8'd1,   1'b1, ONE_RESULT},
			'{32'h0000_0001, 8'd1,   1'b0, UNTYPED},
			'{32'h0000_0002, 8'd1,   1'b0, UNTYPED},
			'{32'h0000_FFFF, 8'd1,   1'b0, UNTYPED},
			'{32'h0004_0000, 8'd1,   1'b0, UNTYPED},
			'{32'h7FFF_FFFF, 8'd1,   1'b0, UNTYPED},
			'{32'h7FFF_0000, 8'd1,   1'b0, UNTYPED},
			'{32'h4000_0000, 8'd1,   1'b0, UNTYPED},
			'{32'h5555_5555, 8'd1,   1'b0, UNTYPED},
			'{32'h2AAA_AAAA, 8'd1,   1'b0, UNTYPED},
			'{32'hAAAA_AAAA, 8'd1,   1'b1, NEG_RESULT},
			'{32'h0000_0003, 8'd0,   1'b0, UNTYPED},
			'{32'h0002_0000, 8'd0,   1'b0, UNTYPED},
			'{32'h7FFF_FFFF, 8'd0,   1'b0, UNTYPED},
			'{32'h0001_0000, 8'd0,   1'b1, ONE_RESULT},
			'{32'h0000_0000, 8'd0,   1'b1, ZERO_RESULT},
			'{32'h7FFF_FFFF, 8'd255, 1'b0, UNTYPED},
			'{32'h0000_0001, 8'd255, 1'b0, UNTYPED},
			'{32'h1234_5678, 8'd255, 1'b0, UNTYPED},
			'{32'hEDCB_A987, 8'd255, 1'b1, NEG_RESULT}
		};
		phase_tol = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(3, 254)), 8'd2,
			8'($urandom_range(3, 254))};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].tol != active_tol)
				write_tolerance(directed_rows[i].tol);
			send_word(directed_rows[i].x, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_tolerance(phase_tol[p]);
			no_idle = (p == 3);
			for (int k = 0; k < phase_items[p]; k++) begin
				case ($urandom_range(0, 9))
					0: x = '0;
					1: x = $urandom | 32'h8000_0000;
					2, 3: x = $urandom;
					4, 5, 6: x = $urandom >> $urandom_range(1, 31);
					7: begin
						r = $urandom_range(1, 46340);
						x = r * r;
					end
					8: begin
						r = $urandom_range(1, 46340);
						x = r * r + $urandom_range(0, 2) - 1;
					end
					default: x = $urandom_range(1, 255);
				endcase
				send_word(x, 1'b0, UNTYPED);
				if (p == 0 && k == 100)
					drain_results();
			end
		end
		no_idle = 1'b0;

		drain_results();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/nsr_pkg.sv
sv/nsr_div.sv
sv/nsr_iter.sv
sv/newton_square_root.sv
tb/sv/tb_newton_square_root.sv
